@@ hw/rtl/tclb_pkg.sv @@
// ----------------------------------------------------------------------------
// tclb_pkg
// Shared types, constants and byte-order helpers for the cell blend pipeline.
// ----------------------------------------------------------------------------
package tclb_pkg;

    localparam int CELL_W   = 32;
    localparam int FACTOR_W = 16;
    localparam int GAS_W    = 33;   // decoded cell, covers u32 and s32
    localparam int DIFF_W   = 34;
    localparam int PROD_W   = 51;
    localparam int MAG_W    = 49;
    localparam int QUO_W    = 33;
    localparam int REM_W    = 20;
    localparam int SUM_W    = 35;
    localparam int NSTG     = 8;

    // divisor of the blend step; the divide stages rely on it being 2^16 - 1
    localparam logic [REM_W-1:0] FS_X1 = REM_W'(65535);
    localparam logic [REM_W-1:0] FS_X2 = REM_W'(2 * 65535);
    localparam logic [REM_W-1:0] FS_X3 = REM_W'(3 * 65535);

    // cell type codes
    localparam logic [2:0] CT_U8  = 3'd0;
    localparam logic [2:0] CT_S8  = 3'd1;
    localparam logic [2:0] CT_U16 = 3'd2;
    localparam logic [2:0] CT_S16 = 3'd3;
    localparam logic [2:0] CT_U32 = 3'd4;
    localparam logic [2:0] CT_S32 = 3'd5;

    typedef enum logic [1:0] {
        REG_CELL_TYPE  = 2'd0,
        REG_BYTE_ORDER = 2'd1,
        REG_MIX_WEIGHT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SZ_1,
        SZ_2,
        SZ_4,
        SZ_NONE
    } size_t;

    typedef struct packed {
        logic [2:0]          cell_type;
        logic                msb_first;
        logic [FACTOR_W-1:0] mix_weight;
    } cfg_t;

    typedef struct packed {
        logic signed [GAS_W-1:0] gas;
        logic                    bad;
        logic                    last;
    } side_t;

    function automatic size_t type_size(input logic [2:0] t);
        size_t s;
        case (t)
            CT_U8, CT_S8:   s = SZ_1;
            CT_U16, CT_S16: s = SZ_2;
            CT_U32, CT_S32: s = SZ_4;
            default:        s = SZ_NONE;
        endcase
        return s;
    endfunction

    // Byte reversal within the cell and zeroing of unused upper bytes.
    // Its own inverse, so it serves decode and encode alike.
    function automatic logic [CELL_W-1:0] order_bytes(input logic [CELL_W-1:0] raw,
                                                      input size_t sz,
                                                      input logic be);
        logic [CELL_W-1:0] v;
        case (sz)
            SZ_1: v = {24'b0, raw[7:0]};
            SZ_2: v = be ? {16'b0, raw[7:0], raw[15:8]} : {16'b0, raw[15:0]};
            default: v = be ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
        endcase
        return v;
    endfunction

    function automatic logic signed [GAS_W-1:0] decode_cell(input logic [CELL_W-1:0] raw,
                                                            input logic [2:0] t,
                                                            input logic be);
        logic [CELL_W-1:0]       v;
        logic signed [GAS_W-1:0] d;
        size_t                   sz;
        sz = type_size(t);
        v  = order_bytes(raw, sz, be);
        case (sz)
            SZ_1:    d = t[0] ? {{25{v[7]}}, v[7:0]} : {25'b0, v[7:0]};
            SZ_2:    d = t[0] ? {{17{v[15]}}, v[15:0]} : {17'b0, v[15:0]};
            default: d = t[0] ? {v[31], v} : {1'b0, v};
        endcase
        return d;
    endfunction

endpackage

@@ hw/rtl/tclb_cfg.sv @@
// ----------------------------------------------------------------------------
// tclb_cfg
// Configuration registers: cell type, byte order and blend factor.
// ----------------------------------------------------------------------------
module tclb_cfg
    import tclb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [FACTOR_W-1:0] cfg_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CELL_TYPE:  cfg_next.cell_type  = cfg_data[2:0];
                REG_BYTE_ORDER: cfg_next.msb_first  = cfg_data[0];
                REG_MIX_WEIGHT: cfg_next.mix_weight = cfg_data;
                default:        cfg_next = cfg_reg;   // index past the list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/tclb_decode.sv @@
// ----------------------------------------------------------------------------
// tclb_decode
// Stages 0 and 1: decode both cells, then form the signed difference.
// ----------------------------------------------------------------------------
module tclb_decode
    import tclb_pkg::*;
(
    input  logic                     clk,
    input  logic [1:0]               ld,
    input  cfg_t                     cfg,
    input  logic [CELL_W-1:0]        gasoline_cell,
    input  logic [CELL_W-1:0]        ethanol_cell,
    input  logic                     last_in,
    output logic signed [DIFF_W-1:0] diff,
    output side_t                    side
);

    side_t                    s0_reg, s0_next;
    logic signed [GAS_W-1:0]  eth_reg, eth_next;
    side_t                    s1_reg;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;

    always_comb
    begin
        s0_next.gas  = decode_cell(gasoline_cell, cfg.cell_type, cfg.msb_first);
        s0_next.bad  = (type_size(cfg.cell_type) == SZ_NONE);
        s0_next.last = last_in;
        eth_next     = decode_cell(ethanol_cell, cfg.cell_type, cfg.msb_first);
        diff_next    = DIFF_W'(eth_reg) - DIFF_W'(s0_reg.gas);
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s0_reg  <= s0_next;
            eth_reg <= eth_next;
        end
        if (ld[1])
        begin
            s1_reg   <= s0_reg;
            diff_reg <= diff_next;
        end
    end

    assign diff = diff_reg;
    assign side = s1_reg;

endmodule

@@ hw/rtl/tclb_scale.sv @@
// ----------------------------------------------------------------------------
// tclb_scale
// Stages 2 to 6: multiply by the blend factor, divide by full scale with
// truncation toward zero, add back the gasoline value.
// ----------------------------------------------------------------------------
module tclb_scale
    import tclb_pkg::*;
(
    input  logic                     clk,
    input  logic [4:0]               ld,
    input  cfg_t                     cfg,
    input  logic signed [DIFF_W-1:0] diff,
    input  side_t                    side_in,
    output logic signed [SUM_W-1:0]  sum,
    output side_t                    side_out
);

    side_t                    s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     neg3_reg, neg4_reg, neg5_reg;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic [QUO_W-1:0]         q0_reg, q0_next;
    logic [REM_W-1:0]         mlo_reg;
    logic [QUO_W-1:0]         q05_reg;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [1:0]               fix;
    logic [QUO_W-1:0]         quo;
    logic signed [SUM_W-1:0]  step;

    always_comb
    begin
        // 34 x 17 bit signed product, operands sign-extended to its width
        prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, cfg.mix_weight}));
        mag_next  = prod_reg[PROD_W-1] ? MAG_W'(-prod_reg) : prod_reg[MAG_W-1:0];
        // x / (2^16 - 1) ~ x/2^16 + x/2^32 + x/2^48, low by at most three
        q0_next   = QUO_W'(mag_reg >> 16) + QUO_W'(mag_reg >> 32) + QUO_W'(mag_reg >> 48);
        // remainder of that estimate, below 4 * full scale so 20 bits suffice
        rem_next  = mlo_reg - {q0_reg[3:0], 16'b0} + q0_reg[REM_W-1:0];
        fix       = 2'(rem_reg >= FS_X1) + 2'(rem_reg >= FS_X2) + 2'(rem_reg >= FS_X3);
        quo       = q05_reg + QUO_W'(fix);
        step      = SUM_W'($signed({1'b0, quo}));
        if (neg5_reg)
        begin
            step = -step;
        end
        sum_next  = SUM_W'(s5_reg.gas) + step;
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s2_reg   <= side_in;
            prod_reg <= prod_next;
        end
        if (ld[1])
        begin
            s3_reg   <= s2_reg;
            neg3_reg <= prod_reg[PROD_W-1];
            mag_reg  <= mag_next;
        end
        if (ld[2])
        begin
            s4_reg   <= s3_reg;
            neg4_reg <= neg3_reg;
            q0_reg   <= q0_next;
            mlo_reg  <= mag_reg[REM_W-1:0];
        end
        if (ld[3])
        begin
            s5_reg   <= s4_reg;
            neg5_reg <= neg4_reg;
            q05_reg  <= q0_reg;
            rem_reg  <= rem_next;
        end
        if (ld[4])
        begin
            s6_reg  <= s5_reg;
            sum_reg <= sum_next;
        end
    end

    assign sum      = sum_reg;
    assign side_out = s6_reg;

endmodule

@@ hw/rtl/tclb_encode.sv @@
// ----------------------------------------------------------------------------
// tclb_encode
// Stage 7: saturate to the cell type's range and put the bytes back in order.
// ----------------------------------------------------------------------------
module tclb_encode
    import tclb_pkg::*;
(
    input  logic                    clk,
    input  logic                    ld,
    input  cfg_t                    cfg,
    input  logic signed [SUM_W-1:0] sum,
    input  side_t                   side,
    output logic [CELL_W-1:0]       out_cell,
    output logic                    bad_type,
    output logic                    last_out
);

    size_t                   sz;
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] sat;
    logic [CELL_W-1:0]       cell_reg, cell_next;
    logic                    bad_reg;
    logic                    last_reg;

    always_comb
    begin
        sz = type_size(cfg.cell_type);
        case (sz)
            SZ_1:
            begin
                lo = cfg.cell_type[0] ? -35'sd128 : 35'sd0;
                hi = cfg.cell_type[0] ? 35'sd127 : 35'sd255;
            end
            SZ_2:
            begin
                lo = cfg.cell_type[0] ? -35'sd32768 : 35'sd0;
                hi = cfg.cell_type[0] ? 35'sd32767 : 35'sd65535;
            end
            default:
            begin
                lo = cfg.cell_type[0] ? -35'sd2147483648 : 35'sd0;
                hi = cfg.cell_type[0] ? 35'sd2147483647 : 35'sd4294967295;
            end
        endcase
        if (sum < lo)
        begin
            sat = lo;
        end
        else if (sum > hi)
        begin
            sat = hi;
        end
        else
        begin
            sat = sum;
        end
        cell_next = side.bad ? '0 : order_bytes(sat[CELL_W-1:0], sz, cfg.msb_first);
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            cell_reg <= cell_next;
            bad_reg  <= side.bad;
            last_reg <= side.last;
        end
    end

    assign out_cell = cell_reg;
    assign bad_type = bad_reg;
    assign last_out = last_reg;

endmodule

@@ hw/rtl/typed_cell_linear_blend.sv @@
// ----------------------------------------------------------------------------
// typed_cell_linear_blend
// Blends a gasoline and an ethanol table cell of configurable type and
// byte order: gas + (eth - gas) * factor / 65535, saturated and re-encoded.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries gasoline_cell, ethanol_cell and
//   last_in; output channel out_valid/out_ready carries out_cell, bad_type
//   and last_out, one result per input transfer, in order.
//   The config channel cfg_valid/cfg_ready writes the cell type (index 0),
//   byte order (1) and mix weight (2); cfg_ready is always high. Write it
//   only while no item is in flight.
//   Eight register stages: decode (0 and 1), scale (2 to 6) and encode (7);
//   out_valid is the valid bit of stage 7, the last of them.
//   One item per cycle is sustained while out_ready stays high.
//   Each stage holds its item only when the stage after it is full and
//   held, so empty stages keep filling while the receiver stalls; in_ready
//   drops once all eight stages hold an item and out_ready is low.
//   Reset clears the valid bits and sets every config register to zero.
// ----------------------------------------------------------------------------
module typed_cell_linear_blend
    import tclb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [FACTOR_W-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CELL_W-1:0]   gasoline_cell,
    input  logic [CELL_W-1:0]   ethanol_cell,
    input  logic                last_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CELL_W-1:0]   out_cell,
    output logic                bad_type,
    output logic                last_out
);

    cfg_t                     cfg;
    logic [NSTG-1:0]          vld_reg, vld_next;
    logic [NSTG-1:0]          ld;
    logic signed [DIFF_W-1:0] diff;
    side_t                    side1;
    logic signed [SUM_W-1:0]  sum;
    side_t                    side6;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        ld[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
        vld_next[0] = ld[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            vld_next[i] = ld[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = vld_reg[NSTG-1];

    tclb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tclb_decode u_decode (
        .clk           (clk),
        .ld            (ld[1:0]),
        .cfg           (cfg),
        .gasoline_cell (gasoline_cell),
        .ethanol_cell  (ethanol_cell),
        .last_in       (last_in),
        .diff          (diff),
        .side          (side1)
    );

    tclb_scale u_scale (
        .clk      (clk),
        .ld       (ld[6:2]),
        .cfg      (cfg),
        .diff     (diff),
        .side_in  (side1),
        .sum      (sum),
        .side_out (side6)
    );

    tclb_encode u_encode (
        .clk      (clk),
        .ld       (ld[7]),
        .cfg      (cfg),
        .sum      (sum),
        .side     (side6),
        .out_cell (out_cell),
        .bad_type (bad_type),
        .last_out (last_out)
    );

endmodule
